// ===== sv/dtft_pkg.sv =====
package dtft_pkg;

    // default widths of the result fields
    localparam int LENGTH_BITS_DEF = 16;
    localparam int COLUMN_BITS_DEF = 10;

    // configuration port
    localparam int APB_ADDR_W  = 5;
    localparam int APB_DATA_W  = 32;
    localparam int FIRST_COL_W = 10;

    // queue between the front and back parts, a power of two
    localparam int QUEUE_DEPTH = 4;

    // special bytes
    localparam logic [7:0] BYTE_LF  = 8'h0A;
    localparam logic [7:0] BYTE_CR  = 8'h0D;
    localparam logic [7:0] BYTE_NUL = 8'h00;

    // configuration reset values
    localparam logic [7:0] RST_ROW_DELIM = BYTE_LF;
    localparam logic [7:0] RST_FLD_SEP   = 8'h2C;

    // register word index on the configuration port
    typedef enum logic [2:0] {
        REG_ROW_DELIM  = 3'd0,
        REG_FLD_SEP    = 3'd1,
        REG_COLL_DELIM = 3'd2,
        REG_ESCAPE     = 3'd3,
        REG_ROWS_DELIM = 3'd4,
        REG_FIRST_COL  = 3'd5
    } t_reg_idx;

    // input item kind
    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_EOB   = 2'd1,
        KIND_CLEAR = 2'd2
    } t_kind;

    // operation handed from the front to the back
    typedef enum logic [2:0] {
        OP_BYTE,
        OP_EOB_SOFT,
        OP_EOB_ROW,
        OP_CLEAR,
        OP_NONE
    } t_op;

    // classified item
    typedef struct packed {
        t_op  op;
        logic is_row;
        logic is_col;
        logic is_esc;
        logic is_cr;
        logic is_lf;
    } t_item;

    // configuration registers
    typedef struct packed {
        logic [7:0]             row_delim;
        logic [7:0]             fld_sep;
        logic [7:0]             coll_delim;
        logic [7:0]             escape;
        logic                   rows_delim;
        logic [FIRST_COL_W-1:0] first_col;
    } t_cfg;

    // queue status
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    // back part status
    typedef struct packed {
        logic pop;
        t_op  op;
        logic len_zero;
    } t_back_stat;

endpackage

// ===== sv/delimited_text_field_tokenizer.sv =====
// a result is shown in the cycle after the back part takes the item that closes its field
// throughput: one item per cycle while results are taken, set by the state update in the back part
// a four-entry queue between classification and state update absorbs output stalls
// reset: synchronous, active low; registers return to defaults, parser state clears,
// queue empties and no result is shown
module delimited_text_field_tokenizer #(
    parameter int LENGTH_BITS = dtft_pkg::LENGTH_BITS_DEF,
    parameter int COLUMN_BITS = dtft_pkg::COLUMN_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [dtft_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [dtft_pkg::APB_DATA_W-1:0] pwdata,
    output logic [dtft_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    // input items
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [1:0]                      i_kind,
    input  logic [7:0]                      i_data_byte,
    // results
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [LENGTH_BITS-1:0]          o_field_length,
    output logic                            o_field_escaped,
    output logic [COLUMN_BITS-1:0]          o_column_index,
    output logic                            o_row_end
);

    dtft_pkg::t_cfg       w_cfg;
    dtft_pkg::t_item      w_front_item;
    dtft_pkg::t_item      w_q_item;
    dtft_pkg::t_q_stat    w_q_stat;
    dtft_pkg::t_back_stat w_back_stat;
    logic                 w_push;
    logic                 w_pop;

    // configuration registers
    dtft_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // input classification
    dtft_front u_front (
        .i_valid     (i_valid),
        .i_kind      (i_kind),
        .i_data_byte (i_data_byte),
        .i_cfg       (w_cfg),
        .i_q_stat    (w_q_stat),
        .o_ready     (o_ready),
        .o_push      (w_push),
        .o_item      (w_front_item)
    );

    // queue between front and back
    dtft_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_front_item),
        .i_pop   (w_pop),
        .o_item  (w_q_item),
        .o_stat  (w_q_stat)
    );

    // parser state and result register
    dtft_back #(
        .LENGTH_BITS (LENGTH_BITS),
        .COLUMN_BITS (COLUMN_BITS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (w_cfg),
        .i_item          (w_q_item),
        .i_q_stat        (w_q_stat),
        .i_ready         (i_ready),
        .o_pop           (w_pop),
        .o_valid         (o_valid),
        .o_field_length  (o_field_length),
        .o_field_escaped (o_field_escaped),
        .o_column_index  (o_column_index),
        .o_row_end       (o_row_end),
        .o_stat          (w_back_stat)
    );

    // a transfer into an empty queue is waiting there in the next cycle
    a_queue_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && w_q_stat.empty) |=> !w_q_stat.empty)
        else $error("transfer into empty queue lost");

    // parser reset leaves an empty length count
    a_clear_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_back_stat.pop && w_back_stat.op == dtft_pkg::OP_CLEAR) |=> w_back_stat.len_zero)
        else $error("length count not cleared by parser reset");

    // undelimited end of buffer always closes the row
    a_eob_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_back_stat.pop && w_back_stat.op == dtft_pkg::OP_EOB_ROW) |=> (o_valid && o_row_end))
        else $error("end of buffer did not close the row");

endmodule

// ===== sv/dtft_regs.sv =====
module dtft_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [dtft_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [dtft_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [dtft_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    output dtft_pkg::t_cfg                    o_cfg
);

    dtft_pkg::t_cfg     r_cfg;
    dtft_pkg::t_reg_idx w_idx;
    logic               w_wr;

    assign pready = 1'b1;
    assign w_idx  = dtft_pkg::t_reg_idx'(paddr[dtft_pkg::APB_ADDR_W-1:2]);
    assign w_wr   = psel && penable && pwrite;
    assign o_cfg  = r_cfg;

    // register writes in the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.row_delim  <= dtft_pkg::RST_ROW_DELIM;
            r_cfg.fld_sep    <= dtft_pkg::RST_FLD_SEP;
            r_cfg.coll_delim <= dtft_pkg::BYTE_NUL;
            r_cfg.escape     <= dtft_pkg::BYTE_NUL;
            r_cfg.rows_delim <= 1'b1;
            r_cfg.first_col  <= '0;
        end else if (w_wr) begin
            case (w_idx)
                dtft_pkg::REG_ROW_DELIM:  r_cfg.row_delim  <= pwdata[7:0];
                dtft_pkg::REG_FLD_SEP:    r_cfg.fld_sep    <= pwdata[7:0];
                dtft_pkg::REG_COLL_DELIM: r_cfg.coll_delim <= pwdata[7:0];
                dtft_pkg::REG_ESCAPE:     r_cfg.escape     <= pwdata[7:0];
                dtft_pkg::REG_ROWS_DELIM: r_cfg.rows_delim <= pwdata[0];
                dtft_pkg::REG_FIRST_COL:
                    r_cfg.first_col <= pwdata[dtft_pkg::FIRST_COL_W-1:0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        prdata = '0;
        case (w_idx)
            dtft_pkg::REG_ROW_DELIM:  prdata[7:0] = r_cfg.row_delim;
            dtft_pkg::REG_FLD_SEP:    prdata[7:0] = r_cfg.fld_sep;
            dtft_pkg::REG_COLL_DELIM: prdata[7:0] = r_cfg.coll_delim;
            dtft_pkg::REG_ESCAPE:     prdata[7:0] = r_cfg.escape;
            dtft_pkg::REG_ROWS_DELIM: prdata[0]   = r_cfg.rows_delim;
            dtft_pkg::REG_FIRST_COL:
                prdata[dtft_pkg::FIRST_COL_W-1:0] = r_cfg.first_col;
            default: ;
        endcase
    end

endmodule

// ===== sv/dtft_front.sv =====
module dtft_front (
    input  logic              i_valid,
    input  logic [1:0]        i_kind,
    input  logic [7:0]        i_data_byte,
    input  dtft_pkg::t_cfg    i_cfg,
    input  dtft_pkg::t_q_stat i_q_stat,
    output logic              o_ready,
    output logic              o_push,
    output dtft_pkg::t_item   o_item
);

    logic w_row_match;

    assign o_ready = !i_q_stat.full;
    assign o_push  = i_valid && !i_q_stat.full;

    // newline as row delimiter also takes carriage return
    assign w_row_match = (i_data_byte == i_cfg.row_delim)
                      || (i_cfg.row_delim == dtft_pkg::BYTE_LF
                          && i_data_byte == dtft_pkg::BYTE_CR);

    // byte classification against the configured delimiters and operation decode
    always_comb begin
        o_item.is_row = i_cfg.rows_delim && w_row_match;
        o_item.is_col = (i_data_byte == i_cfg.fld_sep)
                     || (i_cfg.coll_delim != dtft_pkg::BYTE_NUL
                         && i_data_byte == i_cfg.coll_delim);
        o_item.is_esc = (i_cfg.escape != dtft_pkg::BYTE_NUL)
                     && (i_data_byte == i_cfg.escape);
        o_item.is_cr  = (i_data_byte == dtft_pkg::BYTE_CR);
        o_item.is_lf  = (i_data_byte == dtft_pkg::BYTE_LF);
        case (dtft_pkg::t_kind'(i_kind))
            dtft_pkg::KIND_DATA:  o_item.op = dtft_pkg::OP_BYTE;
            dtft_pkg::KIND_EOB:
                o_item.op = i_cfg.rows_delim ? dtft_pkg::OP_EOB_SOFT : dtft_pkg::OP_EOB_ROW;
            dtft_pkg::KIND_CLEAR: o_item.op = dtft_pkg::OP_CLEAR;
            default:              o_item.op = dtft_pkg::OP_NONE;
        endcase
    end

endmodule

// ===== sv/dtft_queue.sv =====
module dtft_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  dtft_pkg::t_item   i_item,
    input  logic              i_pop,
    output dtft_pkg::t_item   o_item,
    output dtft_pkg::t_q_stat o_stat
);

    localparam int PTR_W = $clog2(dtft_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(dtft_pkg::QUEUE_DEPTH + 1);

    dtft_pkg::t_item  r_mem [dtft_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_item       = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_count == CNT_W'(dtft_pkg::QUEUE_DEPTH));
    assign o_stat.empty = (r_count == '0);

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== sv/dtft_back.sv =====
module dtft_back #(
    parameter int LENGTH_BITS = dtft_pkg::LENGTH_BITS_DEF,
    parameter int COLUMN_BITS = dtft_pkg::COLUMN_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  dtft_pkg::t_cfg         i_cfg,
    input  dtft_pkg::t_item        i_item,
    input  dtft_pkg::t_q_stat      i_q_stat,
    input  logic                   i_ready,
    output logic                   o_pop,
    output logic                   o_valid,
    output logic [LENGTH_BITS-1:0] o_field_length,
    output logic                   o_field_escaped,
    output logic [COLUMN_BITS-1:0] o_column_index,
    output logic                   o_row_end,
    output dtft_pkg::t_back_stat   o_stat
);

    localparam int CMP_W = (COLUMN_BITS > dtft_pkg::FIRST_COL_W)
                         ? COLUMN_BITS : dtft_pkg::FIRST_COL_W;

    // parser state
    logic                   r_pend,    n_pend;
    logic                   r_has_esc, n_has_esc;
    logic                   r_after_cr, n_after_cr;
    logic [LENGTH_BITS-1:0] r_len,     n_len;
    logic [COLUMN_BITS-1:0] r_col,     n_col;

    // result register
    logic                   r_valid,   n_valid;
    logic [LENGTH_BITS-1:0] r_out_len, n_out_len;
    logic                   r_out_esc, n_out_esc;
    logic [COLUMN_BITS-1:0] r_out_col, n_out_col;
    logic                   r_out_row, n_out_row;

    logic [CMP_W-1:0]       w_first_ext;
    logic [CMP_W-1:0]       w_col_max_ext;
    logic [COLUMN_BITS-1:0] w_start;
    logic                   w_new_row;
    logic                   w_new_col;
    logic                   w_esc_now;
    logic                   w_emit;
    logic                   w_emit_row;

    // take the next item when the result register is free or draining
    assign o_pop = !i_q_stat.empty && (!r_valid || i_ready);

    // start column, saturated to the column range
    assign w_first_ext   = CMP_W'(i_cfg.first_col);
    assign w_col_max_ext = CMP_W'({COLUMN_BITS{1'b1}});
    assign w_start       = (w_first_ext > w_col_max_ext) ? {COLUMN_BITS{1'b1}}
                                                         : w_first_ext[COLUMN_BITS-1:0];

    // state update for one item
    always_comb begin
        n_pend     = r_pend;
        n_has_esc  = r_has_esc;
        n_after_cr = r_after_cr;
        n_len      = r_len;
        n_col      = r_col;
        n_valid    = r_valid && !i_ready;
        n_out_len  = r_out_len;
        n_out_esc  = r_out_esc;
        n_out_col  = r_out_col;
        n_out_row  = r_out_row;
        w_new_row  = 1'b0;
        w_new_col  = 1'b0;
        w_esc_now  = r_has_esc;
        w_emit     = 1'b0;
        w_emit_row = 1'b0;
        if (o_pop) begin
            case (i_item.op)
                dtft_pkg::OP_CLEAR: begin
                    n_pend     = 1'b0;
                    n_has_esc  = 1'b0;
                    n_after_cr = 1'b0;
                    n_len      = '0;
                    n_col      = w_start;
                end
                dtft_pkg::OP_EOB_SOFT: begin
                    n_len = '0;
                end
                dtft_pkg::OP_EOB_ROW: begin
                    w_emit     = 1'b1;
                    w_emit_row = 1'b1;
                end
                dtft_pkg::OP_BYTE: begin
                    // a pending escape suppresses this delimiter
                    w_new_row = !r_pend && i_item.is_row;
                    w_new_col = !r_pend && (i_item.is_row || i_item.is_col);
                    if (i_item.is_esc) begin
                        w_esc_now = 1'b1;
                        n_pend    = !r_pend;
                    end else begin
                        n_pend    = 1'b0;
                    end
                    n_has_esc = w_esc_now;
                    if (w_new_row) begin
                        n_after_cr = i_item.is_cr;
                        // lf straight after a row-ending cr is swallowed
                        if (r_after_cr && i_item.is_lf) begin
                            n_len = '0;
                        end else begin
                            w_emit     = 1'b1;
                            w_emit_row = 1'b1;
                        end
                    end else begin
                        n_after_cr = 1'b0;
                        if (w_new_col) begin
                            w_emit = 1'b1;
                        end else if (r_len != {LENGTH_BITS{1'b1}}) begin
                            n_len = r_len + 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
        // close the field and load the result register
        if (w_emit) begin
            n_valid   = 1'b1;
            n_out_len = r_len;
            n_out_esc = w_esc_now;
            n_out_col = r_col;
            n_out_row = w_emit_row;
            n_has_esc = 1'b0;
            n_len     = '0;
            if (w_emit_row) begin
                n_col = w_start;
            end else if (r_col != {COLUMN_BITS{1'b1}}) begin
                n_col = r_col + 1'b1;
            end
        end
    end

    // control and parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend     <= 1'b0;
            r_has_esc  <= 1'b0;
            r_after_cr <= 1'b0;
            r_len      <= '0;
            r_col      <= '0;
            r_valid    <= 1'b0;
        end else begin
            r_pend     <= n_pend;
            r_has_esc  <= n_has_esc;
            r_after_cr <= n_after_cr;
            r_len      <= n_len;
            r_col      <= n_col;
            r_valid    <= n_valid;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        r_out_len <= n_out_len;
        r_out_esc <= n_out_esc;
        r_out_col <= n_out_col;
        r_out_row <= n_out_row;
    end

    assign o_valid         = r_valid;
    assign o_field_length  = r_out_len;
    assign o_field_escaped = r_out_esc;
    assign o_column_index  = r_out_col;
    assign o_row_end       = r_out_row;

    assign o_stat.pop      = o_pop;
    assign o_stat.op       = i_item.op;
    assign o_stat.len_zero = (r_len == '0);

endmodule
